// File: src/bfoot_pkg.sv
// Shared types, codes and fixed widths of the biped foot trajectory generator.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none
package bfoot_pkg;

	localparam int FRAC_BITS_DEF       = 16;
	localparam int MAX_SAMPLE_SIZE_DEF = 4096;
	localparam int MAX_STEPS_DEF       = 1023;

	localparam int NS_W    = 13;
	localparam int T_W     = 24;
	localparam int POS_W   = 32;
	localparam int WID_W   = 31;
	localparam int STEPS_W = 10;
	localparam int P_W     = NS_W + T_W;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_SAMPLE_SIZE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SS_TIME     = 3'd1;
	localparam logic [IDX_W-1:0] REG_DS_TIME     = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_LENGTH = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_HEIGHT = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP_WIDTH  = 3'd5;
	localparam logic [IDX_W-1:0] REG_STEP_COUNT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_LEFT_FIRST  = 3'd7;

	localparam logic [1:0] SUP_BOTH  = 2'd0;
	localparam logic [1:0] SUP_LEFT  = 2'd1;
	localparam logic [1:0] SUP_RIGHT = 2'd2;

	typedef enum logic [1:0] {
		PH_LEAD_IN,
		PH_WALK,
		PH_LEAD_OUT,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_U2,
		MUL_U3,
		MUL_U4,
		MUL_Y,
		MUL_Z
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_LATCH,
		ST_CALC_P,
		ST_CALC_D,
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_MU2,
		ST_MU3,
		ST_MU4,
		ST_MY,
		ST_MZ,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    calc_p;
		logic    calc_d;
		logic    rest;
		logic    div_init;
		logic    div_step;
		mul_op_t mul_op;
		logic    fin;
	} cmd_t;

	typedef struct packed {
		logic walk;
		logic swing_on;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: src/bfoot_ctrl.sv
// Sequencer of the foot trajectory generator: run setup, divider and multiplier steps.
// Depends on bfoot_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none
module bfoot_ctrl #(
	parameter int FRAC_BITS = bfoot_pkg::FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	input  wire               item_restart,
	output logic              item_stall,
	input  wire bfoot_pkg::sts_t sts,
	output bfoot_pkg::cmd_t   cmd
);
	import bfoot_pkg::*;

	localparam int CW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic          div_last;

	assign div_last   = cnt_q == CW'(FRAC_BITS - 1);
	assign item_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LATCH;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL) cnt_q <= '0;
			else if (state_q == ST_DIV) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_IDLE && item_valid && item_restart) pend_q <= 1'b1;
			else if (state_q == ST_CALC_D) pend_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LATCH:  state_d = ST_CALC_P;
			ST_CALC_P: state_d = ST_CALC_D;
			ST_CALC_D: state_d = pend_q ? ST_EVAL : ST_IDLE;
			ST_IDLE: begin
				if (item_valid) state_d = item_restart ? ST_LATCH : ST_EVAL;
			end
			ST_EVAL:   state_d = (sts.walk && sts.swing_on) ? ST_DIV : ST_FIN;
			ST_DIV:    state_d = div_last ? ST_MU2 : ST_DIV;
			ST_MU2:    state_d = ST_MU3;
			ST_MU3:    state_d = ST_MU4;
			ST_MU4:    state_d = ST_MY;
			ST_MY:     state_d = ST_MZ;
			ST_MZ:     state_d = ST_FIN;
			ST_FIN:    state_d = sts.out_free ? ST_IDLE : ST_FIN;
			default:   state_d = ST_LATCH;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = MUL_NONE;
		unique case (state_q)
			ST_LATCH:  cmd.latch = 1'b1;
			ST_CALC_P: cmd.calc_p = 1'b1;
			ST_CALC_D: cmd.calc_d = 1'b1;
			ST_EVAL: begin
				cmd.div_init = 1'b1;
				cmd.rest     = 1'b1;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_MU2:    cmd.mul_op = MUL_U2;
			ST_MU3:    cmd.mul_op = MUL_U3;
			ST_MU4:    cmd.mul_op = MUL_U4;
			ST_MY:     cmd.mul_op = MUL_Y;
			ST_MZ:     cmd.mul_op = MUL_Z;
			ST_FIN:    cmd.fin = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: src/bfoot_dp.sv
// Datapath of the foot trajectory generator: registers, walk bookkeeping,
// radix-2 divider, shared multiplier and output register. Depends on bfoot_pkg.
`default_nettype none
module bfoot_dp #(
	parameter int FRAC_BITS       = bfoot_pkg::FRAC_BITS_DEF,
	parameter int MAX_SAMPLE_SIZE = bfoot_pkg::MAX_SAMPLE_SIZE_DEF,
	parameter int MAX_STEPS       = bfoot_pkg::MAX_STEPS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	input  wire  [bfoot_pkg::IDX_W-1:0]   cfg_index,
	input  wire  [31:0]                   cfg_data,
	input  wire bfoot_pkg::cmd_t          cmd,
	output bfoot_pkg::sts_t               sts,
	input  wire                           sample_stall,
	output logic                          sample_valid,
	output logic signed [31:0]            left_x,
	output logic signed [31:0]            left_y,
	output logic signed [31:0]            left_z,
	output logic signed [31:0]            right_x,
	output logic signed [31:0]            right_y,
	output logic signed [31:0]            right_z,
	output logic [1:0]                    support,
	output logic                          final_sample,
	output logic                          finished
);
	import bfoot_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int LW  = P_W - F;
	localparam int JW  = LW + 1;
	localparam int RW  = P_W + 1;
	localparam int BW  = F + 3;
	localparam int PRW = POS_W + BW;

	// configuration registers
	logic [NS_W-1:0]    ns_cfg_q;
	logic [T_W-1:0]     ts_cfg_q, tds_cfg_q;
	logic [POS_W-1:0]   s_cfg_q, h_cfg_q;
	logic [WID_W-1:0]   w_cfg_q;
	logic [STEPS_W-1:0] sc_cfg_q;
	logic               lf_cfg_q;

	// run registers
	logic [NS_W-1:0]         ns_q;
	logic [T_W-1:0]          ts_q, tds_q;
	logic signed [POS_W-1:0] s_q, h_q;
	logic [WID_W-2:0]        hw_q;
	logic [STEPS_W-1:0]      steps_q;
	logic [P_W-1:0]          p_q;
	logic [LW-1:0]           len_ds_q;

	// walk state
	phase_t                  phase_q, phase_d;
	logic [JW-1:0]           j_q, j_d, j_nx;
	logic [STEPS_W-1:0]      step_q, step_d, step_nx;
	logic                    swing_left_q;
	logic [POS_W-1:0]        left_base_q, right_base_q, left_lift_q, right_lift_q;
	logic                    commit;

	// arithmetic
	logic [RW-1:0]           rem_q, rem_sh, p_ext;
	logic [F-1:0]            u_q, u2_q, u3_q, u4_q;
	logic signed [POS_W-1:0] y_q, z_q;
	logic [P_W-1:0]          cprod;
	logic signed [POS_W-1:0] mul_a;
	logic signed [BW-1:0]    mul_b;
	logic signed [PRW-1:0]   prod;
	logic [BW-1:0]           a_poly, d_poly;
	logic                    half;
	logic [LW-1:0]           len_ss;
	logic [JW-1:0]           step_len;

	// outputs of the current sample
	logic [POS_W-1:0]        ly, lz, ry, rz;
	logic [1:0]              sup_d;
	logic                    fs_d, fin_d;

	logic [NS_W-1:0]         ns_clamp;
	logic [STEPS_W-1:0]      sc_clamp;

	assign len_ss   = p_q[P_W-1:F];
	assign step_len = JW'(len_ss) + JW'(len_ds_q);
	assign j_nx     = j_q + JW'(1);
	assign step_nx  = step_q + STEPS_W'(1);
	assign half     = (step_q == '0) ||
	                  ((STEPS_W + 1)'(step_q) + (STEPS_W + 1)'(1) >= (STEPS_W + 1)'(steps_q));

	assign ns_clamp = (ns_cfg_q == '0) ? NS_W'(1) :
	                  ((32'(ns_cfg_q) > MAX_SAMPLE_SIZE) ? NS_W'(MAX_SAMPLE_SIZE) : ns_cfg_q);
	assign sc_clamp = (sc_cfg_q < STEPS_W'(2)) ? STEPS_W'(2) :
	                  ((32'(sc_cfg_q) > MAX_STEPS) ? STEPS_W'(MAX_STEPS) : sc_cfg_q);

	assign sts.walk     = phase_q == PH_WALK;
	assign sts.swing_on = {j_q, {F{1'b0}}} < {1'b0, p_q};
	assign sts.out_free = !sample_valid || !sample_stall;

	assign cprod  = P_W'(cmd.calc_p ? ts_q : tds_q) * P_W'(ns_q);
	assign p_ext  = {1'b0, p_q};
	assign rem_sh = {rem_q[RW-2:0], 1'b0};

	assign a_poly = (BW'(u2_q) << 1) + BW'(u2_q) - (BW'(u3_q) << 1);
	assign d_poly = BW'(u2_q) - (BW'(u3_q) << 1) + BW'(u4_q);

	always_comb begin
		mul_a = $signed(POS_W'(u_q));
		mul_b = $signed(BW'(u_q));
		unique case (cmd.mul_op)
			MUL_U3: mul_a = $signed(POS_W'(u2_q));
			MUL_U4: mul_a = $signed(POS_W'(u3_q));
			MUL_Y: begin
				mul_a = s_q;
				mul_b = $signed(a_poly);
			end
			MUL_Z: begin
				mul_a = h_q;
				mul_b = $signed(d_poly);
			end
			default: mul_a = $signed(POS_W'(u_q));
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_cfg_q  <= NS_W'(100);
			ts_cfg_q  <= T_W'(52429);
			tds_cfg_q <= T_W'(13107);
			s_cfg_q   <= POS_W'(19661);
			h_cfg_q   <= POS_W'(3277);
			w_cfg_q   <= WID_W'(13107);
			sc_cfg_q  <= STEPS_W'(4);
			lf_cfg_q  <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SAMPLE_SIZE: ns_cfg_q  <= cfg_data[NS_W-1:0];
				REG_SS_TIME:     ts_cfg_q  <= cfg_data[T_W-1:0];
				REG_DS_TIME:     tds_cfg_q <= cfg_data[T_W-1:0];
				REG_STEP_LENGTH: s_cfg_q   <= cfg_data;
				REG_STEP_HEIGHT: h_cfg_q   <= cfg_data;
				REG_STEP_WIDTH:  w_cfg_q   <= cfg_data[WID_W-1:0];
				REG_STEP_COUNT:  sc_cfg_q  <= cfg_data[STEPS_W-1:0];
				REG_LEFT_FIRST:  lf_cfg_q  <= cfg_data[0];
				default:         lf_cfg_q  <= lf_cfg_q;
			endcase
		end
	end

	always_comb begin
		ly    = left_base_q;
		lz    = left_lift_q;
		ry    = right_base_q;
		rz    = right_lift_q;
		sup_d = SUP_BOTH;
		fs_d  = 1'b0;
		fin_d = 1'b0;
		phase_d = phase_q;
		j_d     = j_q;
		step_d  = step_q;
		commit  = 1'b0;
		unique case (phase_q)
			PH_WALK: begin
				if (swing_left_q) begin
					ly = left_base_q + y_q;
					lz = left_lift_q + z_q;
				end else begin
					ry = right_base_q + y_q;
					rz = right_lift_q + z_q;
				end
				if (j_q < JW'(len_ss)) sup_d = swing_left_q ? SUP_RIGHT : SUP_LEFT;
				if (j_nx >= step_len) begin
					commit = 1'b1;
					j_d    = '0;
					step_d = step_nx;
					if (step_nx >= steps_q) phase_d = PH_LEAD_OUT;
				end else begin
					j_d = j_nx;
				end
			end
			PH_LEAD_IN: begin
				if (j_nx >= JW'(ns_q)) begin
					j_d     = '0;
					step_d  = '0;
					phase_d = (step_len == '0) ? PH_LEAD_OUT : PH_WALK;
				end else begin
					j_d = j_nx;
				end
			end
			PH_LEAD_OUT: begin
				if (j_nx >= JW'(ns_q)) begin
					fs_d    = 1'b1;
					j_d     = '0;
					phase_d = PH_DONE;
				end else begin
					j_d = j_nx;
				end
			end
			PH_DONE: fin_d = 1'b1;
			default: fin_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEAD_IN;
			j_q          <= '0;
			step_q       <= '0;
			swing_left_q <= 1'b1;
			sample_valid <= 1'b0;
		end else begin
			if (cmd.latch) begin
				phase_q      <= PH_LEAD_IN;
				j_q          <= '0;
				step_q       <= '0;
				swing_left_q <= lf_cfg_q;
			end else if (cmd.fin) begin
				phase_q <= phase_d;
				j_q     <= j_d;
				step_q  <= step_d;
				if (commit) swing_left_q <= !swing_left_q;
			end
			if (cmd.fin) sample_valid <= 1'b1;
			else if (!sample_stall) sample_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ns_q         <= ns_clamp;
			ts_q         <= (ts_cfg_q == '0) ? T_W'(1) : ts_cfg_q;
			tds_q        <= tds_cfg_q;
			s_q          <= s_cfg_q;
			h_q          <= h_cfg_q;
			hw_q         <= w_cfg_q[WID_W-1:1];
			steps_q      <= sc_clamp;
			left_base_q  <= '0;
			right_base_q <= '0;
			left_lift_q  <= '0;
			right_lift_q <= '0;
		end else if (cmd.fin && commit) begin
			left_base_q  <= ly;
			left_lift_q  <= lz;
			right_base_q <= ry;
			right_lift_q <= rz;
		end
		if (cmd.calc_p) p_q <= cprod;
		if (cmd.calc_d) len_ds_q <= cprod[P_W-1:F];
		if (cmd.div_init) rem_q <= {j_q, {F{1'b0}}};
		else if (cmd.div_step) begin
			if (rem_sh >= p_ext) begin
				rem_q <= rem_sh - p_ext;
				u_q   <= {u_q[F-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				u_q   <= {u_q[F-2:0], 1'b0};
			end
		end
		if (cmd.rest) begin
			y_q <= half ? (s_q >>> 1) : s_q;
			z_q <= '0;
		end
		unique case (cmd.mul_op)
			MUL_U2: u2_q <= prod[2*F-1:F];
			MUL_U3: u3_q <= prod[2*F-1:F];
			MUL_U4: u4_q <= prod[2*F-1:F];
			MUL_Y:  y_q  <= half ? prod[F+32:F+1] : prod[F+31:F];
			MUL_Z:  z_q  <= half ? prod[F+28:F-3] : prod[F+27:F-4];
			default: u4_q <= u4_q;
		endcase
		if (cmd.fin) begin
			left_x       <= -$signed(POS_W'(hw_q));
			right_x      <= $signed(POS_W'(hw_q));
			left_y       <= ly;
			left_z       <= lz;
			right_y      <= ry;
			right_z      <= rz;
			support      <= sup_d;
			final_sample <= fs_d;
			finished     <= fin_d;
		end
	end

endmodule
`default_nettype wire

// File: src/biped_foot_trajectory_generator.sv
// Top level of the biped foot trajectory generator: controller plus datapath.
// Depends on bfoot_pkg, bfoot_ctrl and bfoot_dp.
//
// Each accepted item yields one sample of both foot poses. While the swing
// foot is moving, the divider first produces u at one quotient bit per
// cycle, then five passes through the one shared multiplier follow; in
// lead-in, lead-out, rest and after the run the sample skips both. An
// item with restart set first latches the registers and computes the
// step lengths. Register writes take effect at the next restart.
`default_nettype none
module biped_foot_trajectory_generator #(
	parameter int FRAC_BITS       = bfoot_pkg::FRAC_BITS_DEF,
	parameter int MAX_SAMPLE_SIZE = bfoot_pkg::MAX_SAMPLE_SIZE_DEF,
	parameter int MAX_STEPS       = bfoot_pkg::MAX_STEPS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [bfoot_pkg::IDX_W-1:0] cfg_index,
	input  wire  [31:0]                 cfg_data,
	input  wire                         item_valid,
	output logic                        item_stall,
	input  wire                         restart,
	output logic                        sample_valid,
	input  wire                         sample_stall,
	output logic signed [31:0]          left_x,
	output logic signed [31:0]          left_y,
	output logic signed [31:0]          left_z,
	output logic signed [31:0]          right_x,
	output logic signed [31:0]          right_y,
	output logic signed [31:0]          right_z,
	output logic [1:0]                  support,
	output logic                        final_sample,
	output logic                        finished
);
	import bfoot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bfoot_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_restart(restart),
		.item_stall(item_stall),
		.sts(sts),
		.cmd(cmd)
	);

	bfoot_dp #(
		.FRAC_BITS(FRAC_BITS),
		.MAX_SAMPLE_SIZE(MAX_SAMPLE_SIZE),
		.MAX_STEPS(MAX_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.sample_stall(sample_stall),
		.sample_valid(sample_valid),
		.left_x(left_x),
		.left_y(left_y),
		.left_z(left_z),
		.right_x(right_x),
		.right_y(right_y),
		.right_z(right_z),
		.support(support),
		.final_sample(final_sample),
		.finished(finished)
	);

endmodule
`default_nettype wire

// File: src/bfoot_chk.sv
// Port checker of the biped foot trajectory generator and its bind statement.
// Depends on bfoot_pkg; sees the top level's ports only.
`default_nettype none
module bfoot_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               sample_valid,
	input wire               sample_stall,
	input wire signed [31:0] left_x,
	input wire signed [31:0] left_y,
	input wire signed [31:0] right_x,
	input wire [1:0]         support,
	input wire               final_sample,
	input wire               finished
);
	import bfoot_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(left_y))
		else $error("stalled beat changed");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> !(final_sample && finished))
		else $error("final and finished flags together");

	a_sup: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (support == SUP_BOTH || support == SUP_LEFT ||
		                  support == SUP_RIGHT))
		else $error("bad support code");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (left_x + right_x) == 32'sd0)
		else $error("feet not symmetric about the center line");

endmodule

bind biped_foot_trajectory_generator bfoot_chk u_chk (.*);
`default_nettype wire

// File: tb/sv/tb_biped_foot_trajectory_generator.sv
// Self-checking testbench for biped_foot_trajectory_generator.
// Each output beat is checked against a walk predictor, or for fixed rows a start pose.
// Depends on bfoot_pkg and the generator RTL.
`timescale 1ns / 1ps
module tb_biped_foot_trajectory_generator;
	import bfoot_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [31:0] lx, ly, lz, rx, ry, rz;
		logic [1:0]  sup;
		logic        last_s;
		logic        done;
	} pose_t;

	typedef struct {
		bit    rs;
		bit    fixed;
		pose_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic restart = 1'b0;
	logic sample_valid;
	logic sample_stall = 1'b0;
	logic signed [31:0] left_x, left_y, left_z, right_x, right_y, right_z;
	logic [1:0] support;
	logic final_sample, finished;

	biped_foot_trajectory_generator uut (.*);

	always #5 clk = ~clk;

	// Walk predictor state.
	bit [31:0] reg_val [8];
	int reg_w [8] = '{13, 24, 24, 32, 32, 31, 10, 1};
	longint unsigned run_samples, run_steps, run_p, len_ss, len_ds;
	longint run_s, half_w;
	longint coef [5];
	phase_t walk_ph;
	longint unsigned step_num, sip;
	bit [31:0] lbase, rbase, llift, rlift;
	bit swing_left;

	pose_t pose_q [$];
	int fails = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 0;
	int cycles = 0;

	function automatic void latch_run();
		longint unsigned ns, ts, nst;
		longint h;
		ns = reg_val[0];
		ts = reg_val[1];
		nst = reg_val[6];
		if (ns < 1) ns = 1;
		if (ns > MAX_SAMPLE_SIZE_DEF) ns = MAX_SAMPLE_SIZE_DEF;
		if (ts == 0) ts = 1;
		if (nst < 2) nst = 2;
		if (nst > MAX_STEPS_DEF) nst = MAX_STEPS_DEF;
		run_samples = ns;
		run_steps = nst;
		run_p = ns * ts;
		len_ss = run_p >> FB;
		len_ds = (ns * reg_val[2]) >> FB;
		run_s = longint'(signed'(reg_val[3]));
		h = longint'(signed'(reg_val[4]));
		half_w = longint'(reg_val[5] >> 1);
		coef[0] = 3 * run_s;
		coef[1] = -2 * run_s;
		coef[2] = 16 * h;
		coef[3] = -32 * h;
		coef[4] = 16 * h;
		walk_ph = PH_LEAD_IN;
		step_num = 0;
		sip = 0;
		lbase = 0;
		rbase = 0;
		llift = 0;
		rlift = 0;
		swing_left = reg_val[7][0];
	endfunction

	function automatic pose_t next_pose(bit rs);
		pose_t p;
		longint y, z;
		longint unsigned u, u2, u3, u4, step_len;
		bit half;
		bit [31:0] ly, lz, ry, rz;
		if (rs) latch_run();
		step_len = len_ss + len_ds;
		p.sup = SUP_BOTH;
		p.last_s = 0;
		p.done = 0;
		while (walk_ph == PH_WALK) begin
			if (step_num >= run_steps) begin
				walk_ph = PH_LEAD_OUT;
				sip = 0;
			end else if (step_len == 0) begin
				swing_left = !swing_left;
				step_num++;
			end else begin
				break;
			end
		end
		ly = lbase;
		lz = llift;
		ry = rbase;
		rz = rlift;
		case (walk_ph)
			PH_WALK: begin
				half = (step_num == 0) || (step_num + 1 >= run_steps);
				if ((sip << FB) < run_p) begin
					u = (sip << (2 * FB)) / run_p;
					u2 = (u * u) >> FB;
					u3 = (u2 * u) >> FB;
					u4 = (u3 * u) >> FB;
					y = (coef[0] * longint'(u2) + coef[1] * longint'(u3)) >>> FB;
					z = (coef[2] * longint'(u2) + coef[3] * longint'(u3)
						+ coef[4] * longint'(u4)) >>> FB;
				end else begin
					y = run_s;
					z = 0;
				end
				if (half) begin
					y = y >>> 1;
					z = z >>> 1;
				end
				if (swing_left) begin
					ly = lbase + y[31:0];
					lz = llift + z[31:0];
				end else begin
					ry = rbase + y[31:0];
					rz = rlift + z[31:0];
				end
				if (sip < len_ss) p.sup = swing_left ? SUP_RIGHT : SUP_LEFT;
				sip++;
				if (sip >= step_len) begin
					lbase = ly;
					llift = lz;
					rbase = ry;
					rlift = rz;
					swing_left = !swing_left;
					step_num++;
					sip = 0;
					if (step_num >= run_steps) walk_ph = PH_LEAD_OUT;
				end
			end
			PH_LEAD_IN: begin
				sip++;
				if (sip >= run_samples) begin
					walk_ph = PH_WALK;
					sip = 0;
					step_num = 0;
				end
			end
			PH_LEAD_OUT: begin
				sip++;
				if (sip >= run_samples) begin
					p.last_s = 1;
					walk_ph = PH_DONE;
					sip = 0;
				end
			end
			default: p.done = 1;
		endcase
		p.lx = 32'(-half_w);
		p.rx = 32'(half_w);
		p.ly = ly;
		p.lz = lz;
		p.ry = ry;
		p.rz = rz;
		return p;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		pose_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && sample_valid && !sample_stall) begin
			if (pose_q.size() == 0) begin
				$error("output beat with no expected sample");
				fails++;
			end else begin
				w = pose_q.pop_front();
				check_field("left_x", w.lx, left_x);
				check_field("left_y", w.ly, left_y);
				check_field("left_z", w.lz, left_z);
				check_field("right_x", w.rx, right_x);
				check_field("right_y", w.ry, right_y);
				check_field("right_z", w.rz, right_z);
				check_field("support", 32'(w.sup), 32'(support));
				check_field("final_sample", 32'(w.last_s), 32'(final_sample));
				check_field("finished", 32'(w.done), 32'(finished));
			end
		end
	end

	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 0;
				sample_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				sample_stall <= ($urandom_range(99) < stall_pct);
				@(posedge clk);
			end
		end
	end

	task automatic offer(bit rs, bit fixed, pose_t want);
		pose_t p;
		item_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (item_stall);
		p = next_pose(rs);
		pose_q.push_back(fixed ? want : p);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			restart <= $urandom_range(1);
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(bit [31:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[IDX_W-1:0];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			reg_val[i] = (reg_w[i] == 32) ? vals[i] : vals[i] & ((32'd1 << reg_w[i]) - 1);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic walk_items(int n, int idle, int stall);
		pose_t none;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			offer(i == 0 || $urandom_range(39) == 0, 0, none);
		drain();
	endtask

	initial begin
		dir_row_t dir_tab [$];
		dir_row_t row;
		pose_t start_pose;
		bit [31:0] vals [8];
		int modes [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{32, 32}};

		for (int i = 0; i < 8; i++) begin
			reg_val[i] = 0;
		end
		reg_val[0] = 100;
		reg_val[1] = 52429;
		reg_val[2] = 13107;
		reg_val[3] = 19661;
		reg_val[4] = 3277;
		reg_val[5] = 13107;
		reg_val[6] = 4;
		reg_val[7] = 1;
		latch_run();

		start_pose = '{lx: 32'hFFFF_E667, ly: 0, lz: 0, rx: 32'd6553, ry: 0, rz: 0,
			sup: SUP_BOTH, last_s: 0, done: 0};
		for (int i = 0; i < 24; i++) begin
			row.rs = (i == 10) || (i == 17);
			row.fixed = (i == 0) || (i == 10);
			row.want = start_pose;
			dir_tab.push_back(row);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) offer(dir_tab[i].rs, dir_tab[i].fixed, dir_tab[i].want);
		drain();

		// Clamped minimum registers: every step is empty and is skipped.
		vals = '{0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0};
		write_regs(vals);
		walk_items(40, 0, 0);
		// Register maxima, sample_size clamped.
		vals = '{8191, 24'hFFFFFF, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1023, 1};
		write_regs(vals);
		walk_items(40, 0, 0);
		// Swing running past the end of single support.
		vals = '{3, 32'h8000, 32'h10000, 32'h0002_0000, 32'h0000_8000, 32'h1000, 3, 1};
		write_regs(vals);
		walk_items(40, 0, 0);
		vals = '{1, 32'h30000, 0, 32'hFFFE_0000, 32'hFFFF_0000, 32'h2001, 2, 0};
		write_regs(vals);
		walk_items(40, 32, 32);

		// Receiver holds off while items keep coming.
		vals = '{2, 32'h28000, 32'h8000, 32'h12345, 32'h4321, 32'h100, 4, 1};
		write_regs(vals);
		hold_req = 1;
		walk_items(60, 0, 0);

		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 8; i++) vals[i] = $urandom;
			if (k % 4 != 3) begin
				vals[0] = $urandom_range(1, 6);
				vals[1] = $urandom_range(1, 4 * 65536);
				vals[2] = $urandom_range(0, 2 * 65536);
				vals[6] = $urandom_range(2, 6);
			end
			write_regs(vals);
			walk_items(100, modes[k % 4][0], modes[k % 4][1]);
		end

		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
src/bfoot_pkg.sv
src/bfoot_ctrl.sv
src/bfoot_dp.sv
src/biped_foot_trajectory_generator.sv
src/bfoot_chk.sv
tb/sv/tb_biped_foot_trajectory_generator.sv
